@@ hdl/fsc_pkg.sv @@
// Shared types, constants and helper functions for the frustum sphere culling core.
package fsc_pkg;

   // Field and storage widths.
   localparam int COORD_W     = 32;
   localparam int RADIUS_W    = 31;
   localparam int LEN_W       = 32;
   localparam int REG_W       = 64;
   localparam int PROD_W      = 64;
   localparam int SQ_W        = 63;
   localparam int TH_W        = 63;
   localparam int NUM_REGS    = 8;
   localparam int NUM_PLANES  = 6;
   localparam int PLANE_IDX_W = 3;
   localparam int CSR_IDX_W   = 4;

   // Result queue sizing; deeper than the cell chain so a free receiver sees full rate.
   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = 4;
   localparam int QCNT_W      = 5;

   // Register indexes of the matrix words.
   localparam logic [CSR_IDX_W-1:0] REG_COL0_R01 = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COL0_R23 = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COL1_R01 = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COL1_R23 = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COL2_R01 = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COL2_R23 = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COL3_R01 = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_COL3_R23 = 4'd7;

   // Matrix register file, word 0 in the lowest slot.
   typedef logic [NUM_REGS-1:0][REG_W-1:0] regfile_type;

   // Reset contents, listed from word 7 down to word 0.
   localparam regfile_type REG_RESET = {
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
   };

   localparam logic signed [COORD_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COEF_MIN = 32'sh8000_0000;

   // One sphere moving down the cell chain.
   typedef struct packed {
      logic                       valid;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic signed [COORD_W-1:0]  z;
      logic        [RADIUS_W-1:0] r;
      logic                       visible;
   } item_type;

   // One frustum plane with the length of its normal.
   typedef struct packed {
      logic signed [COORD_W-1:0] a;
      logic signed [COORD_W-1:0] b;
      logic signed [COORD_W-1:0] c;
      logic signed [COORD_W-1:0] d;
      logic        [LEN_W-1:0]   len;
   } plane_type;

   // Plane load issued by the setup sequencer.
   typedef struct packed {
      logic                   we;
      logic [PLANE_IDX_W-1:0] sel;
      plane_type              plane;
   } plane_load_type;

   // Matrix entry m[col][row] as signed fixed point.
   function automatic logic signed [COORD_W-1:0] mat_entry(regfile_type rf, logic [1:0] col,
                                                           logic [1:0] row);
      logic [REG_W-1:0] word;
      word = rf[{col, row[1]}];
      return row[0] ? $signed(word[REG_W-1:COORD_W]) : $signed(word[COORD_W-1:0]);
   endfunction

   // Sum or difference of two entries, saturated to the signed 32-bit range.
   function automatic logic signed [COORD_W-1:0] sat_coef(logic signed [COORD_W-1:0] m3,
                                                          logic signed [COORD_W-1:0] mk,
                                                          logic neg);
      logic signed [COORD_W:0] s;
      s = neg ? (33'(m3) - 33'(mk)) : (33'(m3) + 33'(mk));
      if (s[COORD_W] != s[COORD_W-1]) begin
         return s[COORD_W] ? COEF_MIN : COEF_MAX;
      end
      return s[COORD_W-1:0];
   endfunction

endpackage

@@ hdl/frustum_sphere_cull_core.sv @@
// Top level of the frustum sphere culling core: matrix registers, setup, cell chain and queue.
//
// Usage: the csr channel writes the eight 64-bit words of the column-major view-projection
// matrix (csr_index 0 to 7; other indexes are ignored; csr_ready is always high). Each
// write restarts plane setup. Setup extracts the six planes and takes a square root per
// plane, so the block holds req_stall high after every write and after reset until all six
// planes are loaded, then runs with the reset identity matrix or the written one.
// Each request carries a sphere center and radius; the response gives one bit, high when
// the sphere touches or lies inside the frustum. Requests pass a chain of six cells, one
// plane each. A response is offered once its request has left the last cell and been
// written to the queue; one request per cycle is taken while req_stall is low. Responses
// leave in order through a 16-entry queue; when the receiver stalls, the chain keeps running
// and the queue absorbs results, and req_stall rises only once 16 requests are outstanding.
// Reset is synchronous and clears all control state.
module frustum_sphere_cull_core
   import fsc_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [COORD_W-1:0]  req_center_x,
   input  logic signed [COORD_W-1:0]  req_center_y,
   input  logic signed [COORD_W-1:0]  req_center_z,
   input  logic        [RADIUS_W-1:0] req_sphere_radius,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_inside_res,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic        [CSR_IDX_W-1:0] csr_index,
   input  logic        [REG_W-1:0]    csr_data
);

   regfile_type    regs_ff, regs_in;
   logic           csr_write;
   logic           seq_busy;
   logic           queue_full;
   logic           accept;
   plane_load_type load;
   item_type       chain [NUM_PLANES+1];

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // Matrix register writes.
   always_comb begin
      regs_in = regs_ff;
      if (csr_write) begin
         unique case (csr_index) inside
            REG_COL0_R01, REG_COL0_R23, REG_COL1_R01, REG_COL1_R23,
            REG_COL2_R01, REG_COL2_R23, REG_COL3_R01, REG_COL3_R23: begin
               regs_in[csr_index[PLANE_IDX_W-1:0]] = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= REG_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   // Plane setup after reset and after every matrix write.
   fsc_plane_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_write),
      .regs    (regs_in),
      .busy    (seq_busy),
      .load    (load)
   );

   assign req_stall = seq_busy | queue_full;
   assign accept    = req_valid & ~req_stall;

   // Head of the chain.
   always_comb begin
      chain[0].valid   = accept;
      chain[0].x       = req_center_x;
      chain[0].y       = req_center_y;
      chain[0].z       = req_center_z;
      chain[0].r       = req_sphere_radius;
      chain[0].visible = 1'b1;
   end

   // One cell per plane.
   for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
      fsc_cull_cell #(
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .load_we    (load.we && (load.sel == PLANE_IDX_W'(i))),
         .load_plane (load.plane),
         .item_in    (chain[i]),
         .item_out   (chain[i+1])
      );
   end

   fsc_result_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .wr_valid (chain[NUM_PLANES].valid),
      .wr_data  (chain[NUM_PLANES].visible),
      .rd_stall (rsp_stall),
      .full     (queue_full),
      .rd_valid (rsp_valid),
      .rd_data  (rsp_inside_res)
   );

endmodule

@@ hdl/fsc_plane_seq.sv @@
// Plane setup sequencer: extracts each plane and finds its normal length by integer square root.
module fsc_plane_seq
   import fsc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           restart,
   input  regfile_type    regs,
   output logic           busy,
   output plane_load_type load
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_SUM    = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [PLANE_IDX_W-1:0] idx_ff, idx_in;
   plane_type              plane_ff, plane_in;
   logic [SQ_W-1:0]        sqa_ff, sqa_in, sqb_ff, sqb_in, sqc_ff, sqc_in;
   logic [PROD_W-1:0]      n_ff, n_in, res_ff, res_in, bit_ff, bit_in;

   logic signed [COORD_W-1:0] coef [4];
   logic signed [PROD_W-1:0]  prod_a, prod_b, prod_c;
   logic [PROD_W-1:0]         trial;

   // Coefficients of the selected plane: row 3 plus or minus row k of each column.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         coef[c] = sat_coef(mat_entry(regs, 2'(c), 2'd3),
                            mat_entry(regs, 2'(c), idx_ff[2:1]), idx_ff[0]);
      end
   end

   assign prod_a = 64'(coef[0]) * 64'(coef[0]);
   assign prod_b = 64'(coef[1]) * 64'(coef[1]);
   assign prod_c = 64'(coef[2]) * 64'(coef[2]);
   assign trial  = res_ff + bit_ff;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      plane_in = plane_ff;
      sqa_in   = sqa_ff;
      sqb_in   = sqb_ff;
      sqc_in   = sqc_ff;
      n_in     = n_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_SQUARE: begin
            plane_in.a = coef[0];
            plane_in.b = coef[1];
            plane_in.c = coef[2];
            plane_in.d = coef[3];
            sqa_in     = prod_a[SQ_W-1:0];
            sqb_in     = prod_b[SQ_W-1:0];
            sqc_in     = prod_c[SQ_W-1:0];
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            n_in     = 64'(sqa_ff) + 64'(sqb_ff) + 64'(sqc_ff);
            res_in   = '0;
            bit_in   = 64'd1 << (PROD_W - 2);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            // One result bit per cycle, restoring square root.
            if (n_ff >= trial) begin
               n_in   = n_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == 64'd1) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            plane_in.len = res_ff[LEN_W-1:0];
            if (idx_ff == PLANE_IDX_W'(NUM_PLANES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SQUARE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (restart) begin
         state_in = ST_SQUARE;
         idx_in   = '0;
      end
   end

   // Control state restarts the setup pass after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SQUARE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      plane_ff <= plane_in;
      sqa_ff   <= sqa_in;
      sqb_ff   <= sqb_in;
      sqc_ff   <= sqc_in;
      n_ff     <= n_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
   end

   // The finished plane goes to its cell in the write step.
   always_comb begin
      load.we        = (state_ff == ST_WRITE);
      load.sel       = idx_ff;
      load.plane     = plane_ff;
      load.plane.len = res_ff[LEN_W-1:0];
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ hdl/fsc_cull_cell.sv @@
// One cell of the culling chain: holds one plane and tests each passing sphere against it.
module fsc_cull_cell
   import fsc_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load_we,
   input  plane_type load_plane,
   input  item_type  item_in,
   output item_type  item_out
);

   plane_type                plane_ff, plane_in;
   item_type                 item_a_ff, item_a_in, item_b_ff, item_b_in;
   logic signed [PROD_W-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic        [TH_W-1:0]   th_ff, th_in;
   logic        [TH_W-1:0]   rlen;
   logic signed [PROD_W-1:0] plane_dist;
   logic signed [PROD_W-1:0] margin;

   // Plane storage, loaded by the setup sequencer.
   assign plane_in = load_we ? load_plane : plane_ff;

   // First stage: the three products and the radius scaled by the normal length.
   assign rlen      = TH_W'(item_in.r) * TH_W'(plane_ff.len);
   assign item_a_in = item_in;
   assign px_in     = 64'(plane_ff.a) * 64'(item_in.x);
   assign py_in     = 64'(plane_ff.b) * 64'(item_in.y);
   assign pz_in     = 64'(plane_ff.c) * 64'(item_in.z);
   assign th_in     = (plane_ff.len == '0) ? TH_W'(item_in.r) : (rlen >> FRAC_BITS);

   // Second stage: floored distance, then reject when it falls below minus the threshold.
   assign plane_dist = (px_ff >>> FRAC_BITS) + (py_ff >>> FRAC_BITS) + (pz_ff >>> FRAC_BITS)
                     + 64'(plane_ff.d);
   assign margin = plane_dist + $signed({1'b0, th_ff});

   always_comb begin
      item_b_in         = item_a_ff;
      item_b_in.visible = item_a_ff.visible & ~margin[PROD_W-1];
   end

   // Valid bits are control state; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_a_ff.valid <= 1'b0;
         item_b_ff.valid <= 1'b0;
      end else begin
         item_a_ff.valid <= item_a_in.valid;
         item_b_ff.valid <= item_b_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      plane_ff          <= plane_in;
      item_a_ff.x       <= item_a_in.x;
      item_a_ff.y       <= item_a_in.y;
      item_a_ff.z       <= item_a_in.z;
      item_a_ff.r       <= item_a_in.r;
      item_a_ff.visible <= item_a_in.visible;
      item_b_ff.x       <= item_b_in.x;
      item_b_ff.y       <= item_b_in.y;
      item_b_ff.z       <= item_b_in.z;
      item_b_ff.r       <= item_b_in.r;
      item_b_ff.visible <= item_b_in.visible;
      px_ff             <= px_in;
      py_ff             <= py_in;
      pz_ff             <= pz_in;
      th_ff             <= th_in;
   end

   assign item_out = item_b_ff;

endmodule

@@ hdl/fsc_result_queue.sv @@
// Result queue with credit count; it parts the free-running cell chain from the receiver.
module fsc_result_queue
   import fsc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic wr_valid,
   input  logic wr_data,
   input  logic rd_stall,
   output logic full,
   output logic rd_valid,
   output logic rd_data
);

   logic [QUEUE_DEPTH-1:0] mem_ff, mem_in;
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]      fill_ff, fill_in, credit_ff, credit_in;
   logic                   pop;

   assign pop = rd_valid & ~rd_stall;

   // Storage and pointers.
   always_comb begin
      mem_in = mem_ff;
      if (wr_valid) begin
         mem_in[wr_ptr_ff] = wr_data;
      end
      wr_ptr_in = wr_ptr_ff + QPTR_W'(wr_valid);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      fill_in   = fill_ff + QCNT_W'(wr_valid) - QCNT_W'(pop);
      // Outstanding requests: accepted and not yet delivered.
      credit_in = credit_ff + QCNT_W'(accept) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
   end

   assign full     = (credit_ff == QCNT_W'(QUEUE_DEPTH));
   assign rd_valid = (fill_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the frustum sphere culling core with a built-in plane-test predictor.
`timescale 1ns / 100ps

module tb_top;
   import fsc_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int NEAR_SPAN = 8 * ONE;
   localparam int NUM_KINDS = 6;
   localparam int PHASES    = 12;
   localparam int PHASE_REQUESTS = 60;

   localparam logic [RADIUS_W-1:0]  RAD_MAX      = '1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_NONE = '1;

   // Ways of building the view-projection matrix for a phase.
   typedef enum int {
      SET_PERSPECTIVE,
      SET_AFFINE,
      SET_RAW,
      SET_EXTREME,
      SET_FLAT,
      SET_RESET
   } matrix_kind_type;

   // Matrix entries indexed [col][row]; the bit layout matches the register file.
   typedef logic [3:0][3:0][COORD_W-1:0] matrix_grid_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic signed [COORD_W-1:0]  z;
      logic        [RADIUS_W-1:0] r;
   } sphere_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [COORD_W-1:0]  req_center_x = '0;
   logic signed [COORD_W-1:0]  req_center_y = '0;
   logic signed [COORD_W-1:0]  req_center_z = '0;
   logic        [RADIUS_W-1:0] req_sphere_radius = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_inside_res;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic        [CSR_IDX_W-1:0] csr_index = '0;
   logic        [REG_W-1:0]    csr_data = '0;

   // Predictor copy of the matrix registers.
   regfile_type cull_matrix = REG_RESET;

   sphere_type sphere_queue[$];
   bit      inside_expected[$];
   sphere_type next_sphere;
   bit      expected_inside_bit;
   bit      req_fired = 1'b0;
   int      burst_left = 0;
   int      gap_left = 0;
   int      stall_left = 0;
   logic [15:0] stall_pattern = '0;
   int      fail_count = 0;

   frustum_sphere_cull_core #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_center_z     (req_center_z),
      .req_sphere_radius(req_sphere_radius),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inside_res   (rsp_inside_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Signed matrix entry m[col][row] from the predictor registers.
   function automatic longint matrix_entry(int col, int row);
      logic [REG_W-1:0]          word;
      logic signed [COORD_W-1:0] half;
      word = cull_matrix[col * 2 + row / 2];
      half = (row % 2 == 1) ? word[REG_W-1:COORD_W] : word[COORD_W-1:0];
      return longint'(half);
   endfunction

   // Row 3 plus or minus row k of one column, clamped to the signed 32-bit range.
   function automatic longint plane_coef(int col, int k, bit neg);
      longint sum;
      sum = neg ? matrix_entry(col, 3) - matrix_entry(col, k)
                : matrix_entry(col, 3) + matrix_entry(col, k);
      if (sum > longint'(COEF_MAX)) begin
         return longint'(COEF_MAX);
      end
      if (sum < longint'(COEF_MIN)) begin
         return longint'(COEF_MIN);
      end
      return sum;
   endfunction

   // Sphere test against all six planes; false as soon as one plane rejects.
   function automatic bit sphere_inside(logic signed [COORD_W-1:0] cx,
                                        logic signed [COORD_W-1:0] cy,
                                        logic signed [COORD_W-1:0] cz,
                                        logic [RADIUS_W-1:0] rad);
      longint    a, b, c, d, reach, plane_dist;
      bit [63:0] norm_sq, norm_len, trial;
      for (int p = 0; p < NUM_PLANES; p++) begin
         a = plane_coef(0, p / 2, p % 2 == 1);
         b = plane_coef(1, p / 2, p % 2 == 1);
         c = plane_coef(2, p / 2, p % 2 == 1);
         d = plane_coef(3, p / 2, p % 2 == 1);
         norm_sq = a * a + b * b + c * c;
         // Bitwise integer square root, floor of the exact root.
         norm_len = '0;
         for (int i = 31; i >= 0; i--) begin
            trial = norm_len | (64'd1 << i);
            if (trial * trial <= norm_sq) begin
               norm_len = trial;
            end
         end
         // A plane with a zero normal is compared unscaled against the radius.
         if (norm_len == 0) begin
            reach = longint'(rad);
         end else begin
            reach = longint'((64'(rad) * norm_len) >> FRAC_BITS);
         end
         plane_dist = ((a * cx) >>> FRAC_BITS) + ((b * cy) >>> FRAC_BITS)
                    + ((c * cz) >>> FRAC_BITS) + d;
         if (plane_dist < -reach) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic [COORD_W-1:0] edge_value();
      case ($urandom_range(0, 4))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2: return '0;
         3: return 32'd1;
         default: return '1;
      endcase
   endfunction

   // Mostly small spheres near the origin, with full-range and boundary values mixed in.
   function automatic sphere_type random_sphere();
      sphere_type s;
      case ($urandom_range(0, 9))
         7: begin
            s.x = $urandom;
            s.y = $urandom;
            s.z = $urandom;
            s.r = RADIUS_W'($urandom);
         end
         8: begin
            s.x = edge_value();
            s.y = edge_value();
            s.z = edge_value();
            s.r = RADIUS_W'(edge_value());
         end
         default: begin
            s.x = 32'($urandom_range(0, 2 * NEAR_SPAN)) - 32'(NEAR_SPAN);
            s.y = 32'($urandom_range(0, 2 * NEAR_SPAN)) - 32'(NEAR_SPAN);
            s.z = 32'($urandom_range(0, 2 * NEAR_SPAN)) - 32'(NEAR_SPAN);
            s.r = ($urandom_range(0, 3) == 0) ? '0 : 31'($urandom_range(0, 2 * ONE));
         end
      endcase
      return s;
   endfunction

   function automatic logic [COORD_W-1:0] small_value(int span);
      return 32'($urandom_range(0, 2 * span)) - 32'(span);
   endfunction

   task automatic queue_sphere(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic signed [COORD_W-1:0] z,
                               input logic [RADIUS_W-1:0] r);
      sphere_queue.push_back('{x: x, y: y, z: z, r: r});
   endtask

   // Block until every queued request has been sent and answered.
   task automatic wait_drained();
      do @(posedge clock);
      while (sphere_queue.size() != 0 || req_valid || inside_expected.size() != 0);
   endtask

   task automatic write_matrix_word(input logic [CSR_IDX_W-1:0] idx,
                                    input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < NUM_REGS) begin
         cull_matrix[idx] = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_matrix(input regfile_type words);
      for (int w = 0; w < NUM_REGS; w++) begin
         write_matrix_word(CSR_IDX_W'(w), words[w]);
      end
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (gap_left > 0 || sphere_queue.size() == 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end
            req_valid <= 1'b0;
         end else begin
            next_sphere = sphere_queue.pop_front();
            req_center_x      <= next_sphere.x;
            req_center_y      <= next_sphere.y;
            req_center_z      <= next_sphere.z;
            req_sphere_radius <= next_sphere.r;
            req_valid         <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 32);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // Response stall: a 16-bit pattern, replaced with a new random one from time to time.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(0, 4))
            0: stall_pattern = '0;
            1: stall_pattern = 16'($urandom);
            2: stall_pattern = 16'($urandom & $urandom);
            3: stall_pattern = 16'($urandom | $urandom);
            default: stall_pattern = '1;
         endcase
         stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      rsp_stall <= stall_pattern[stall_left % 16];
   end

   // Request monitor: predict the answer for each accepted request.
   always @(posedge clock) begin
      req_fired <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         inside_expected.push_back(sphere_inside(req_center_x, req_center_y,
                                                 req_center_z, req_sphere_radius));
      end
   end

   // Response checker: compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (inside_expected.size() == 0) begin
            $error("inside_res: response with no request outstanding, actual %0b",
                   rsp_inside_res);
            fail_count++;
         end else begin
            expected_inside_bit = inside_expected.pop_front();
            if (rsp_inside_res !== expected_inside_bit) begin
               $error("inside_res mismatch: expected %0b, actual %0b",
                      expected_inside_bit, rsp_inside_res);
               fail_count++;
            end
         end
      end
   end

   // Stimulus phases.
   initial begin
      matrix_grid_type grid;
      matrix_kind_type kind;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset identity matrix: the frustum is the cube from -1 to +1.
      queue_sphere(0, 0, 0, 0);
      queue_sphere(ONE, 0, 0, 0);
      queue_sphere(ONE + 1, 0, 0, 0);
      queue_sphere(0, -ONE - 1, 0, 0);
      queue_sphere(0, 0, ONE + 1, 0);
      queue_sphere(ONE + ONE / 2, 0, 0, RADIUS_W'(ONE / 2));
      queue_sphere(ONE + ONE / 2, 0, 0, RADIUS_W'(ONE / 2 - 1));
      queue_sphere(COEF_MAX, COEF_MAX, COEF_MAX, RAD_MAX);
      queue_sphere(COEF_MIN, COEF_MIN, COEF_MIN, 0);
      queue_sphere(COEF_MAX, COEF_MIN, 0, RAD_MAX);
      queue_sphere(-1, -1, -1, 1);
      wait_drained();

      // A write beyond the register list must leave the matrix alone.
      write_matrix_word(CSR_IDX_NONE, {$urandom, $urandom});
      queue_sphere(ONE + 1, 0, 0, 0);
      queue_sphere(0, ONE, 0, 0);
      wait_drained();

      // Every normal is zero, so each plane compares d against the radius.
      grid = '0;
      grid[3][3] = -2 * ONE;
      program_matrix(regfile_type'(grid));
      queue_sphere(COEF_MAX, 0, COEF_MIN, RADIUS_W'(2 * ONE - 1));
      queue_sphere(0, 0, 0, RADIUS_W'(2 * ONE));
      queue_sphere(0, 0, 0, RAD_MAX);
      queue_sphere(5, 5, 5, 0);
      wait_drained();

      // Coefficient sums and differences that overflow and clamp.
      grid = '0;
      grid[0][3] = COEF_MAX;
      grid[0][0] = COEF_MAX;
      grid[1][3] = COEF_MIN;
      grid[1][1] = 1;
      grid[2][3] = COEF_MIN;
      grid[2][2] = COEF_MIN;
      grid[3][3] = COEF_MAX;
      grid[3][0] = COEF_MAX;
      program_matrix(regfile_type'(grid));
      queue_sphere(0, 0, 0, 0);
      queue_sphere(ONE, -ONE, ONE, RADIUS_W'(ONE));
      queue_sphere(COEF_MIN, COEF_MAX, COEF_MIN, RAD_MAX);
      wait_drained();

      // Random phases, each under a fresh matrix.
      for (int phase = 0; phase < PHASES; phase++) begin
         kind = matrix_kind_type'(phase % NUM_KINDS);
         grid = '0;
         case (kind)
            SET_PERSPECTIVE: begin
               grid[0][0] = $urandom_range(ONE / 2, 3 * ONE);
               grid[1][1] = $urandom_range(ONE / 2, 3 * ONE);
               grid[2][2] = -$urandom_range(ONE, ONE + ONE / 4);
               grid[2][3] = -ONE;
               grid[3][2] = -$urandom_range(ONE / 16, 2 * ONE);
               program_matrix(regfile_type'(grid));
               write_matrix_word(CSR_IDX_W'($urandom_range(NUM_REGS, CSR_IDX_NONE)),
                                 {$urandom, $urandom});
            end
            SET_AFFINE: begin
               for (int col = 0; col < 4; col++) begin
                  for (int row = 0; row < 3; row++) begin
                     grid[col][row] = small_value(2 * ONE);
                  end
               end
               grid[3][3] = ONE;
               program_matrix(regfile_type'(grid));
            end
            SET_RAW: begin
               program_matrix({NUM_REGS{$urandom, $urandom}});
               for (int w = 0; w < NUM_REGS; w++) begin
                  write_matrix_word(CSR_IDX_W'(w), {$urandom, $urandom});
               end
            end
            SET_EXTREME: begin
               for (int col = 0; col < 4; col++) begin
                  for (int row = 0; row < 4; row++) begin
                     grid[col][row] = edge_value();
                  end
               end
               program_matrix(regfile_type'(grid));
            end
            SET_FLAT: begin
               for (int row = 0; row < 4; row++) begin
                  grid[3][row] = small_value(4 * ONE);
               end
               program_matrix(regfile_type'(grid));
            end
            default: begin
               program_matrix(REG_RESET);
            end
         endcase
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            sphere_queue.push_back(random_sphere());
         end
         wait_drained();
      end

      // Let the pipeline run out so any stray response is caught.
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ frustum_sphere_cull_core.f @@
hdl/fsc_pkg.sv
hdl/fsc_plane_seq.sv
hdl/fsc_cull_cell.sv
hdl/fsc_result_queue.sv
hdl/frustum_sphere_cull_core.sv
bench/tb_top.sv
